>>> hdl/lspm_pkg.sv
// Shared types and constants for the LED segment pixel mapper.
// No dependencies; compile first.
package lspm_pkg;

   localparam int unsigned DEF_PIXELS = 1024;
   localparam int unsigned NUM_CHAN   = 5;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 15;

   localparam logic [0:0] OP_WRITE = 1'b0;
   localparam logic [0:0] OP_READ  = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_SEG_START  = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_STOP   = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GRP_COUNT  = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_GRP_SPACE  = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PHASE      = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MODE       = 4'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_ORDER      = 4'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_BRIGHT     = 4'd7;

   localparam logic [2:0] SLOT_LIMIT = 3'd5;

   typedef logic [NUM_CHAN-1:0][7:0] colour_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_BASE,
      ST_GROUP,
      ST_TGT,
      ST_MIRROR,
      ST_DIRECT,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

endpackage

>>> hdl/lspm_req_if.sv
// Request channel of the LED segment pixel mapper: one pixel write or read per beat.
// Depends on lspm_pkg.
interface lspm_req_if;
   import lspm_pkg::*;

   logic       valid;
   logic       ready;
   logic [0:0] opcode;
   logic [9:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] warm_white;
   logic [7:0] cold_white;
   logic       apply_brightness;

   modport source (output valid, opcode, pixel_index, red, green, blue, warm_white,
                   cold_white, apply_brightness, input ready);
   modport sink   (input valid, opcode, pixel_index, red, green, blue, warm_white,
                   cold_white, apply_brightness, output ready);
endinterface

>>> hdl/lspm_rsp_if.sv
// Response channel of the LED segment pixel mapper: one result beat per request.
// Depends on lspm_pkg.
interface lspm_rsp_if;
   import lspm_pkg::*;

   logic        valid;
   logic        ready;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic [7:0]  out_warm_white;
   logic [7:0]  out_cold_white;
   logic [15:0] physical_address;
   logic [8:0]  pixels_written;
   logic        out_of_range;

   modport source (output valid, out_red, out_green, out_blue, out_warm_white,
                   out_cold_white, physical_address, pixels_written, out_of_range,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_warm_white,
                   out_cold_white, physical_address, pixels_written, out_of_range,
                   output ready);
endinterface

>>> hdl/lspm_csr_if.sv
// Register write channel of the LED segment pixel mapper.
// Depends on lspm_pkg.
interface lspm_csr_if;
   import lspm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

>>> hdl/led_segment_pixel_mapper_core.sv
// Top level of the LED segment pixel mapper: configuration registers, sequencer
// and the pixel store memory. Depends on lspm_pkg and the three channel interfaces.
//
// Usage: req_bus carries one pixel write or read per beat, rsp_bus returns one
// result beat per request, csr_bus writes the eight configuration registers and
// is always ready. Write configuration only while no request is in flight.
// After reset the block sweeps the pixel store to zero, one entry per cycle,
// over all PIXELS entries; req_bus.ready stays low during that pass.
// Steps: a read passes MAP, BASE, RD_ADDR and RD_DATA, then DONE loads the output
// register. A write passes MAP and BASE, then for each of group_count group pixels
// GROUP and TGT, plus DIRECT when it lies inside the segment (MIRROR and DIRECT when
// mirrored), then DONE. The store has a single write port, one address per cycle.
// One request is in work at a time; the next is taken as soon as the
// sequencer is idle, even while the previous result waits in the output
// register. When the receiver stalls, the result holds and a finished second
// request waits in its last step until the output register frees.
module led_segment_pixel_mapper_core #(
   parameter int unsigned PIXELS = lspm_pkg::DEF_PIXELS
) (
   input  logic          clock,
   input  logic          reset,
   lspm_req_if.sink      req_bus,
   lspm_rsp_if.source    rsp_bus,
   lspm_csr_if.sink      csr_bus
);
   import lspm_pkg::*;

   localparam int unsigned AW = $clog2(PIXELS);

   // configuration
   logic [10:0] start_ff, stop_ff;
   logic [7:0]  gcount_ff, gspace_ff, bright_ff;
   logic [9:0]  phase_ff;
   logic [1:0]  mode_ff;
   logic [14:0] order_ff;

   // sequencer and datapath
   state_type            state_ff, state_in;
   logic [0:0]           op_ff, op_in;
   logic [9:0]           idx_ff, idx_in;
   logic                 apply_ff, apply_in;
   colour_type           hw_ff, hw_in;
   logic [NUM_CHAN-1:0][15:0] scl_ff, scl_in;
   logic [15:0]          prod_ff, prod_in;
   logic [15:0]          rbase_ff, rbase_in;
   logic [15:0]          len_ff, len_in;
   logic [15:0]          p_ff, p_in;
   logic [7:0]           j_ff, j_in;
   logic [15:0]          s_ff, s_in;
   logic [15:0]          m_ff, m_in;
   logic                 first_ff, first_in;
   logic [15:0]          addr_ff, addr_in;
   logic [8:0]           written_ff, written_in;
   logic                 oor_ff, oor_in;
   colour_type           res_ff, res_in;
   logic [AW-1:0]        clr_ff, clr_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   colour_type           rsp_col_ff, rsp_col_in;
   logic [15:0]          rsp_addr_ff, rsp_addr_in;
   logic [8:0]           rsp_written_ff, rsp_written_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   // pixel store
   logic [NUM_CHAN*8-1:0] mem [PIXELS];
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   colour_type            mem_wdata;
   colour_type            rd_q_ff;

   logic [15:0] start16, stop16, tgt;
   logic        tgt_in_store;
   colour_type  req_col;

   function automatic colour_type fwd_perm(colour_type col, logic [14:0] ord);
      colour_type hw;
      logic [2:0] s;
      hw = col;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s = ord[3*c +: 3];
         if (s < SLOT_LIMIT) hw[s] = col[c];
      end
      return hw;
   endfunction

   function automatic colour_type inv_perm(colour_type hw, logic [14:0] ord);
      colour_type res;
      logic [2:0] s;
      res = hw;
      for (int c = 0; c < NUM_CHAN; c++) begin
         s = ord[3*c +: 3];
         if (s < SLOT_LIMIT) res[c] = hw[s];
      end
      return res;
   endfunction

   function automatic logic [7:0] div255(logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

   function automatic logic [15:0] wrap_off(logic [15:0] a, logic [9:0] off,
                                             logic [15:0] stop, logic [15:0] len);
      logic [15:0] t;
      t = a + {6'd0, off};
      if (t >= stop) t = t - len;
      return t;
   endfunction

   assign start16 = {5'd0, start_ff};
   assign stop16  = {5'd0, stop_ff};
   assign req_col = {req_bus.cold_white, req_bus.warm_white, req_bus.blue,
                     req_bus.green, req_bus.red};

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 11'd0;
         stop_ff   <= 11'd1024;
         gcount_ff <= 8'd1;
         gspace_ff <= 8'd0;
         phase_ff  <= 10'd0;
         mode_ff   <= 2'd0;
         order_ff  <= 15'd18056;
         bright_ff <= 8'd255;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            REG_SEG_START: start_ff  <= csr_bus.data[10:0];
            REG_SEG_STOP:  stop_ff   <= csr_bus.data[10:0];
            REG_GRP_COUNT: gcount_ff <= csr_bus.data[7:0];
            REG_GRP_SPACE: gspace_ff <= csr_bus.data[7:0];
            REG_PHASE:     phase_ff  <= csr_bus.data[9:0];
            REG_MODE:      mode_ff   <= csr_bus.data[1:0];
            REG_ORDER:     order_ff  <= csr_bus.data[14:0];
            REG_BRIGHT:    bright_ff <= csr_bus.data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      tgt = (state_ff == ST_MIRROR) ? wrap_off(m_ff, phase_ff, stop16, len_ff)
                                    : wrap_off(s_ff, phase_ff, stop16, len_ff);
      if (state_ff == ST_RD_ADDR) begin
         tgt = (len_ff != 16'd0) ? wrap_off(p_ff, phase_ff, stop16, len_ff) : p_ff;
      end
      tgt_in_store = {1'b0, tgt} < 17'(PIXELS);
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      apply_in       = apply_ff;
      hw_in          = hw_ff;
      scl_in         = scl_ff;
      prod_in        = prod_ff;
      rbase_in       = rbase_ff;
      len_in         = len_ff;
      p_in           = p_ff;
      j_in           = j_ff;
      s_in           = s_ff;
      m_in           = m_ff;
      first_in       = first_ff;
      addr_in        = addr_ff;
      written_in     = written_ff;
      oor_in         = oor_ff;
      res_in         = res_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_col_in     = rsp_col_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_written_in = rsp_written_ff;
      rsp_oor_in     = rsp_oor_ff;
      req_bus.ready  = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = tgt[AW-1:0];
      mem_raddr      = tgt[AW-1:0];
      mem_wdata      = hw_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(PIXELS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in    = req_bus.opcode;
               idx_in   = req_bus.pixel_index;
               apply_in = req_bus.apply_brightness;
               hw_in    = fwd_perm(req_col, order_ff);
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            prod_in = {6'd0, idx_ff} * ({8'd0, gcount_ff} + {8'd0, gspace_ff});
            for (int c = 0; c < NUM_CHAN; c++) scl_in[c] = {8'd0, hw_ff[c]} * {8'd0, bright_ff};
            len_in  = stop16 - start16;
            rbase_in = mode_ff[1] ? {1'b0, 15'((stop16 - start16 - 16'd1) >> 1)}
                                  : (stop16 - start16 - 16'd1);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            p_in = (mode_ff[0] ? (rbase_ff - prod_ff) : prod_ff) + start16;
            if (apply_ff) begin
               for (int c = 0; c < NUM_CHAN; c++) hw_in[c] = div255(scl_ff[c]);
            end
            j_in       = 8'd0;
            first_in   = 1'b1;
            addr_in    = 16'd0;
            written_in = 9'd0;
            oor_in     = 1'b0;
            res_in     = '0;
            state_in   = (op_ff == OP_READ) ? ST_RD_ADDR : ST_GROUP;
         end
         ST_GROUP: begin
            if (j_ff == gcount_ff) begin
               state_in = ST_DONE;
            end else begin
               s_in     = mode_ff[0] ? (p_ff - {8'd0, j_ff}) : (p_ff + {8'd0, j_ff});
               j_in     = j_ff + 8'd1;
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            m_in = stop16 + start16 - 16'd1 - s_ff;
            if (s_ff < start16 || s_ff >= stop16) state_in = ST_GROUP;
            else state_in = mode_ff[1] ? ST_MIRROR : ST_DIRECT;
         end
         ST_MIRROR, ST_DIRECT: begin
            if (first_ff) begin
               addr_in  = tgt;
               first_in = 1'b0;
            end
            if (tgt_in_store) begin
               mem_we     = 1'b1;
               written_in = written_ff + 9'd1;
            end else begin
               oor_in = 1'b1;
            end
            state_in = (state_ff == ST_MIRROR) ? ST_DIRECT : ST_GROUP;
         end
         ST_RD_ADDR: begin
            addr_in  = tgt;
            oor_in   = !tgt_in_store;
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            res_in   = oor_ff ? '0 : inv_perm(rd_q_ff, order_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_col_in     = res_ff;
               rsp_addr_in    = addr_ff;
               rsp_written_in = written_ff;
               rsp_oor_in     = oor_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      apply_ff       <= apply_in;
      hw_ff          <= hw_in;
      scl_ff         <= scl_in;
      prod_ff        <= prod_in;
      rbase_ff       <= rbase_in;
      len_ff         <= len_in;
      p_ff           <= p_in;
      j_ff           <= j_in;
      s_ff           <= s_in;
      m_ff           <= m_in;
      first_ff       <= first_in;
      addr_ff        <= addr_in;
      written_ff     <= written_in;
      oor_ff         <= oor_in;
      res_ff         <= res_in;
      rsp_col_ff     <= rsp_col_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_written_ff <= rsp_written_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_q_ff <= mem[mem_raddr];
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.out_red          = rsp_col_ff[0];
   assign rsp_bus.out_green        = rsp_col_ff[1];
   assign rsp_bus.out_blue         = rsp_col_ff[2];
   assign rsp_bus.out_warm_white   = rsp_col_ff[3];
   assign rsp_bus.out_cold_white   = rsp_col_ff[4];
   assign rsp_bus.physical_address = rsp_addr_ff;
   assign rsp_bus.pixels_written   = rsp_written_ff;
   assign rsp_bus.out_of_range     = rsp_oor_ff;

endmodule

>>> bench/tb_led_segment_pixel_mapper_core.sv
`timescale 1ns / 100ps
// Testbench for led_segment_pixel_mapper_core: drives pixel write/read beats and register
// writes, predicts every result beat from a shadow pixel store and compares field by field.
// Depends on lspm_pkg, lspm_req_if, lspm_rsp_if, lspm_csr_if and the core itself.
module tb_led_segment_pixel_mapper_core;
   import lspm_pkg::*;

   localparam int unsigned PIXELS           = DEF_PIXELS;
   localparam int unsigned RANDOM_OPS       = 1700;
   localparam int unsigned WATCHDOG_LIMIT   = 20000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned DRAIN_CYCLES     = 20;
   localparam logic [CSR_ADDR_W-1:0] FIRST_UNUSED_REG = REG_BRIGHT + 1'b1;

   typedef struct packed {
      logic [0:0] opcode;
      logic [9:0] index;
      colour_type colour;
      logic       apply;
   } pixel_op_type;

   typedef struct packed {
      colour_type  colour;
      logic [15:0] address;
      logic [8:0]  written;
      logic        oor;
   } pixel_result_type;

   logic clock;
   logic reset;

   lspm_req_if req_bus ();
   lspm_rsp_if rsp_bus ();
   lspm_csr_if csr_bus ();

   led_segment_pixel_mapper_core #(.PIXELS(PIXELS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   colour_type    pixel_image [PIXELS];
   logic [10:0]   cfg_start;
   logic [10:0]   cfg_stop;
   logic [7:0]    cfg_count;
   logic [7:0]    cfg_space;
   logic [9:0]    cfg_phase;
   logic [1:0]    cfg_mode;
   logic [14:0]   cfg_order;
   logic [7:0]    cfg_bright;

   pixel_op_type     pending_ops [$];
   pixel_result_type expected_beats [$];
   int unsigned   fail_count;
   int unsigned   quiet_cycles;
   int unsigned   burst_left;
   int unsigned   gap_left;
   logic [15:0]   stall_bits;
   logic [3:0]    stall_pos;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      fail_count++;
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   task automatic check_field(string what, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   function automatic void apply_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_SEG_START: cfg_start  = value[10:0];
         REG_SEG_STOP:  cfg_stop   = value[10:0];
         REG_GRP_COUNT: cfg_count  = value[7:0];
         REG_GRP_SPACE: cfg_space  = value[7:0];
         REG_PHASE:     cfg_phase  = value[9:0];
         REG_MODE:      cfg_mode   = value[1:0];
         REG_ORDER:     cfg_order  = value[14:0];
         REG_BRIGHT:    cfg_bright = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [15:0] cfg_len();
      return 16'(cfg_stop) - 16'(cfg_start);
   endfunction

   function automatic logic [15:0] segment_base(logic [9:0] index);
      logic [15:0] glen;
      logic [15:0] lm1;
      logic [15:0] p;
      glen = 16'(cfg_count) + 16'(cfg_space);
      p = 16'(index) * glen;
      lm1 = cfg_len() - 16'd1;
      if (cfg_mode[0])
         p = cfg_mode[1] ? (lm1 / 16'd2) - p : lm1 - p;
      return p + 16'(cfg_start);
   endfunction

   function automatic logic [15:0] offset_wrap(logic [15:0] a);
      logic [15:0] r;
      r = a + 16'(cfg_phase);
      if (r >= 16'(cfg_stop))
         r = r - cfg_len();
      return r;
   endfunction

   function automatic pixel_result_type apply_pixel_op(pixel_op_type op);
      pixel_result_type r;
      colour_type    hw;
      logic [15:0]   p;
      logic [15:0]   s;
      logic [15:0]   a;
      logic [15:0]   tgt [2];
      logic [2:0]    slot;
      int            n_tgt;
      int            c;
      int            j;
      int            t;
      bit            first;
      r = '0;
      first = 1'b1;
      p = segment_base(op.index);
      if (op.opcode == OP_WRITE) begin
         hw = op.colour;
         for (c = 0; c < NUM_CHAN; c++) begin
            slot = cfg_order[3*c +: 3];
            if (slot < SLOT_LIMIT)
               hw[slot] = op.colour[c];
         end
         if (op.apply) begin
            for (c = 0; c < NUM_CHAN; c++)
               hw[c] = 8'((16'(hw[c]) * 16'(cfg_bright)) / 16'd255);
         end
         for (j = 0; j < int'(cfg_count); j++) begin
            s = cfg_mode[0] ? p - 16'(j) : p + 16'(j);
            if (s < 16'(cfg_start) || s >= 16'(cfg_stop))
               continue;
            n_tgt = 0;
            if (cfg_mode[1]) begin
               tgt[n_tgt] = offset_wrap(16'(cfg_stop) - s + 16'(cfg_start) - 16'd1);
               n_tgt++;
            end
            tgt[n_tgt] = offset_wrap(s);
            n_tgt++;
            for (t = 0; t < n_tgt; t++) begin
               a = tgt[t];
               if (first) begin
                  r.address = a;
                  first = 1'b0;
               end
               if (a < PIXELS) begin
                  pixel_image[a] = hw;
                  r.written++;
               end else begin
                  r.oor = 1'b1;
               end
            end
         end
      end else begin
         a = p;
         if (cfg_len() != 16'd0)
            a = offset_wrap(a);
         r.address = a;
         if (a < PIXELS) begin
            hw = pixel_image[a];
            r.colour = hw;
            for (c = 0; c < NUM_CHAN; c++) begin
               slot = cfg_order[3*c +: 3];
               if (slot < SLOT_LIMIT)
                  r.colour[c] = hw[slot];
            end
         end else begin
            r.oor = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic pixel_op_type make_op(logic [0:0] opcode, int index, colour_type colour,
                                            logic apply);
      pixel_op_type op;
      op.opcode = opcode;
      op.index  = 10'(index);
      op.colour = colour;
      op.apply  = apply;
      return op;
   endfunction

   function automatic colour_type random_colour();
      colour_type col;
      int         c;
      int         pick;
      for (c = 0; c < NUM_CHAN; c++) begin
         pick = $urandom_range(0, 9);
         col[c] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      end
      return col;
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, int unsigned value);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg(idx, CSR_DATA_W'(value));
   endtask

   task automatic program_segment(int start, int stop, int count, int space, int phase,
                                  int mode, int order, int bright);
      write_reg(REG_SEG_START, start);
      write_reg(REG_SEG_STOP, stop);
      write_reg(REG_GRP_COUNT, count);
      write_reg(REG_GRP_SPACE, space);
      write_reg(REG_PHASE, phase);
      write_reg(REG_MODE, mode);
      write_reg(REG_ORDER, order);
      write_reg(REG_BRIGHT, bright);
      if ($urandom_range(0, 3) == 0)
         write_reg(FIRST_UNUSED_REG + CSR_ADDR_W'($urandom_range(0, 7)), $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_ops.size() != 0 || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned random_ops;
      int          kind;
      int          start;
      int          stop;
      int          count;
      int          space;
      int          phase;
      int          mode;
      int          order;
      int          bright;
      int          n_ops;
      int          span;
      int          perm [5];
      int          i;
      int          j;
      int          tmp;
      int          idx;

      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.opcode           = OP_WRITE;
      req_bus.pixel_index      = '0;
      req_bus.red              = '0;
      req_bus.green            = '0;
      req_bus.blue             = '0;
      req_bus.warm_white       = '0;
      req_bus.cold_white       = '0;
      req_bus.apply_brightness = 1'b0;
      rsp_bus.ready            = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.addr             = '0;
      csr_bus.data             = '0;
      fail_count               = 0;
      for (i = 0; i < PIXELS; i++)
         pixel_image[i] = '0;
      cfg_start  = 11'd0;
      cfg_stop   = 11'd1024;
      cfg_count  = 8'd1;
      cfg_space  = 8'd0;
      cfg_phase  = 10'd0;
      cfg_mode   = 2'd0;
      cfg_order  = 15'd18056;
      cfg_bright = 8'd255;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: cleared store, plain writes and reads at both ends
      @(negedge clock);
      pending_ops.push_back(make_op(OP_READ, 7, '0, 1'b0));
      pending_ops.push_back(make_op(OP_WRITE, 0, 40'hFF_FF_FF_FF_FF, 1'b0));
      pending_ops.push_back(make_op(OP_WRITE, 1023, 40'h10_08_04_02_01, 1'b1));
      pending_ops.push_back(make_op(OP_READ, 0, '0, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 1023, '0, 1'b0));

      // reversed mirrored segment, clashing and unused slots, half brightness
      wait_idle();
      program_segment(100, 200, 3, 2, 37, 3, 16841, 128);
      @(negedge clock);
      pending_ops.push_back(make_op(OP_WRITE, 0, 40'hA5_5A_C3_3C_F0, 1'b1));
      pending_ops.push_back(make_op(OP_WRITE, 5, 40'h12_34_56_78_9A, 1'b0));
      pending_ops.push_back(make_op(OP_WRITE, 1023, 40'hFF_00_FF_00_FF, 1'b1));
      pending_ops.push_back(make_op(OP_READ, 0, '0, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 5, '0, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 1023, '0, 1'b1));

      // empty segment, no group pixels, every slot unused, zero brightness
      wait_idle();
      program_segment(0, 0, 0, 0, 0, 1, 32767, 0);
      @(negedge clock);
      pending_ops.push_back(make_op(OP_WRITE, 3, 40'hFF_FF_FF_FF_FF, 1'b1));
      pending_ops.push_back(make_op(OP_READ, 0, '0, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 1023, '0, 1'b0));

      // widest groups, mirrored, maximum rotation, all slots on channel zero
      wait_idle();
      program_segment(0, 1024, 255, 255, 1023, 2, 0, 255);
      @(negedge clock);
      pending_ops.push_back(make_op(OP_WRITE, 0, 40'h11_22_33_44_55, 1'b1));
      pending_ops.push_back(make_op(OP_WRITE, 1023, 40'h66_77_88_99_AA, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 0, '0, 1'b0));
      pending_ops.push_back(make_op(OP_READ, 1023, '0, 1'b0));

      random_ops = 0;
      while (random_ops < RANDOM_OPS) begin
         wait_idle();
         kind = $urandom_range(0, 9);
         for (i = 0; i < 5; i++)
            perm[i] = i;
         for (i = 4; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
         end
         order = 0;
         for (i = 0; i < 5; i++)
            order = order | (perm[i] << (3 * i));
         if ($urandom_range(0, 2) == 0)
            order = $urandom_range(0, 32767);
         mode = $urandom_range(0, 3);
         phase = $urandom_range(0, 1023);
         bright = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 255 : 0)
                                            : $urandom_range(0, 255);
         if (kind == 0) begin
            start = $urandom_range(0, 512);
            stop  = start + $urandom_range(0, 512);
            count = $urandom_range(64, 255);
            space = $urandom_range(0, 255);
            n_ops = 6;
         end else if (kind <= 2) begin
            start = $urandom_range(0, 2047);
            stop  = $urandom_range(0, 2047);
            count = $urandom_range(0, 6);
            space = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3);
            n_ops = 40;
         end else begin
            start = $urandom_range(0, 960);
            stop  = start + $urandom_range(1, 1024 - start);
            count = $urandom_range(1, 4);
            space = $urandom_range(0, 3);
            if ($urandom_range(0, 2) != 0)
               phase = $urandom_range(0, stop - start - 1);
            n_ops = 100;
         end
         program_segment(start, stop, count, space, phase, mode, order, bright);
         span = (stop > start && count + space > 0) ? (stop - start) / (count + space) + 1
                                                    : 1023;
         if (span > 1023)
            span = 1023;
         @(negedge clock);
         for (i = 0; i < n_ops; i++) begin
            idx = ($urandom_range(0, 6) != 0) ? $urandom_range(0, span) : $urandom_range(0, 1023);
            pending_ops.push_back(make_op($urandom_range(0, 1) ? OP_READ : OP_WRITE, idx,
                                          random_colour(), 1'($urandom_range(0, 1))));
         end
         random_ops += n_ops;
      end

      while (pending_ops.size() != 0 || expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      pixel_op_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid)
            expected_beats.push_back(apply_pixel_op(pending_ops.pop_front()));
         if (gap_left != 0 || pending_ops.size() == 0) begin
            if (gap_left != 0)
               gap_left--;
            req_bus.valid <= 1'b0;
         end else begin
            head = pending_ops[0];
            req_bus.valid            <= 1'b1;
            req_bus.opcode           <= head.opcode;
            req_bus.pixel_index      <= head.index;
            req_bus.red              <= head.colour[0];
            req_bus.green            <= head.colour[1];
            req_bus.blue             <= head.colour[2];
            req_bus.warm_white       <= head.colour[3];
            req_bus.cold_white       <= head.colour[4];
            req_bus.apply_brightness <= head.apply;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      pixel_result_type want;
      int            pick;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_bits = 16'hFFFF;
         stall_pos  = '0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("result beat with nothing pending", 0, 0);
            end else begin
               want = expected_beats.pop_front();
               check_field("out_red", rsp_bus.out_red, want.colour[0]);
               check_field("out_green", rsp_bus.out_green, want.colour[1]);
               check_field("out_blue", rsp_bus.out_blue, want.colour[2]);
               check_field("out_warm_white", rsp_bus.out_warm_white, want.colour[3]);
               check_field("out_cold_white", rsp_bus.out_cold_white, want.colour[4]);
               check_field("physical_address", rsp_bus.physical_address, want.address);
               check_field("pixels_written", rsp_bus.pixels_written, want.written);
               check_field("out_of_range", rsp_bus.out_of_range, want.oor);
            end
         end
         if (stall_pos == 0) begin
            pick = $urandom_range(0, 3);
            stall_bits = (pick == 0) ? 16'hFFFF :
                         (pick == 1) ? 16'($urandom) :
                         (pick == 2) ? 16'($urandom) | 16'($urandom) :
                                       (16'($urandom) & 16'($urandom)) | 16'h0001;
         end
         rsp_bus.ready <= stall_bits[stall_pos];
         stall_pos = stall_pos + 1'b1;
      end
   end

   // hang detection
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
